FILE: hw/rtl/lr4_pkg.sv
// shared types and constants for the lr4 svf crossover
// no dependencies; used by lr4_ctrl, lr4_dp and lr4_svf_crossover_top
package lr4_pkg;

  localparam int SAMPLE_BITS    = 24;
  localparam int COEF_FRAC_BITS = 24;
  localparam int COEF_W         = COEF_FRAC_BITS + 1;
  localparam int STATE_W        = 32;
  localparam int OPB_W          = STATE_W + 1;
  localparam int PROD_W         = COEF_W + 1 + OPB_W;
  localparam int ACC_W          = PROD_W + 1;
  localparam int RND_W          = ACC_W - COEF_FRAC_BITS;

  localparam int NUM_SEC   = 4;
  localparam int SEC_W     = 2;
  localparam int STEP_W    = 3;
  localparam int CFG_IDX_W = 2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_A1 = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_A2 = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_A3 = 2'd2;

  // section order: low 1, high 1, low 2, high 2 (odd index is high-pass)
  localparam logic [SEC_W-1:0] SEC_LOW1  = 2'd0;
  localparam logic [SEC_W-1:0] SEC_HIGH1 = 2'd1;
  localparam logic [SEC_W-1:0] SEC_LOW2  = 2'd2;
  localparam logic [SEC_W-1:0] SEC_HIGH2 = 2'd3;

  // steps of one section
  localparam logic [STEP_W-1:0] STEP_LOAD   = 3'd0;
  localparam logic [STEP_W-1:0] STEP_M_A1   = 3'd1;
  localparam logic [STEP_W-1:0] STEP_M_A2V  = 3'd2;
  localparam logic [STEP_W-1:0] STEP_M_A2I  = 3'd3;
  localparam logic [STEP_W-1:0] STEP_M_A3   = 3'd4;
  localparam logic [STEP_W-1:0] STEP_M_K    = 3'd5;
  localparam logic [STEP_W-1:0] STEP_V2     = 3'd6;
  localparam logic [STEP_W-1:0] STEP_WB     = 3'd7;

  localparam longint unsigned SQRT2_Q30 = 64'd1518500250;
  localparam logic [COEF_W-1:0] K_SQRT2 =
    COEF_W'((SQRT2_Q30 + (64'd1 << (29 - COEF_FRAC_BITS))) >> (30 - COEF_FRAC_BITS));
  localparam logic [COEF_W-1:0] COEF_ONE = {1'b1, {COEF_FRAC_BITS{1'b0}}};

  localparam logic [COEF_W-1:0] COEF_A1_RESET = COEF_W'(64'd16609120);
  localparam logic [COEF_W-1:0] COEF_A2_RESET = COEF_W'(64'd118330);
  localparam logic [COEF_W-1:0] COEF_A3_RESET = COEF_W'(64'd843);

  typedef enum logic [2:0] {
    MS_A1_IC1,
    MS_A2_V3,
    MS_A2_IC1,
    MS_A3_V3,
    MS_K_V1
  } mul_sel_t;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD
  } acc_op_t;

  typedef struct packed {
    logic             take_in;
    logic             load;
    logic [SEC_W-1:0] sec;
    mul_sel_t         mul_sel;
    acc_op_t          acc_op;
    logic             v1_we;
    logic             v2_we;
    logic             wb;
    logic             push;
  } dp_cmd_t;

endpackage

FILE: hw/rtl/lr4_svf_crossover_top.sv
// top level of the 4th-order linkwitz-riley crossover built from svf sections
// depends on lr4_pkg, lr4_ctrl and lr4_dp
//
// usage:
//   in_*  : one transaction per audio sample (in_sample_in, in_block_end),
//           valid/ready handshake
//   out_* : one transaction per sample (out_low_band, out_high_band,
//           out_block_end_out), valid/ready handshake
//   cfg_* : write port for coef_a1/a2/a3 (index 0..2), only while idle;
//           values above one are taken as one, index 3 is ignored
// each sample runs four sections (low 1, high 1, low 2, high 2) one after another
// on one shared multiplier and accumulator, then waits in a hand-off state for a
// free output register; a new sample is taken only once the last one is handed off.
// the output register holds a finished result, so the next sample is taken
// while the receiver stalls; a second result waits until the first is gone.
// reset loads the coefficient reset values and clears all integrators;
// no result is pending afterwards.
module lr4_svf_crossover_top (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     in_valid,
  output logic                                     in_ready,
  input  logic signed [lr4_pkg::SAMPLE_BITS-1:0]   in_sample_in,
  input  logic                                     in_block_end,
  output logic                                     out_valid,
  input  logic                                     out_ready,
  output logic signed [lr4_pkg::SAMPLE_BITS-1:0]   out_low_band,
  output logic signed [lr4_pkg::SAMPLE_BITS-1:0]   out_high_band,
  output logic                                     out_block_end_out,
  input  logic                                     cfg_we,
  input  logic [lr4_pkg::CFG_IDX_W-1:0]            cfg_index,
  input  logic [lr4_pkg::COEF_W-1:0]               cfg_data
);

  lr4_pkg::dp_cmd_t cmd;

  lr4_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  lr4_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_sample_in      (in_sample_in),
    .in_block_end      (in_block_end),
    .cmd               (cmd),
    .out_low_band      (out_low_band),
    .out_high_band     (out_high_band),
    .out_block_end_out (out_block_end_out)
  );

endmodule

FILE: hw/rtl/lr4_ctrl.sv
// sequencer for the lr4 crossover: steps four svf sections through the shared datapath
// depends on lr4_pkg
module lr4_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output lr4_pkg::dp_cmd_t cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } state_t;

  state_t                           state_r, state_nxt;
  logic [lr4_pkg::SEC_W-1:0]        sec_r, sec_nxt;
  logic [lr4_pkg::STEP_W-1:0]       step_r, step_nxt;
  logic                             out_valid_r, out_valid_nxt;
  logic                             push;
  logic                             is_high;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign push      = (state_r == ST_DONE) && (!out_valid_r || out_ready);
  assign is_high   = sec_r[0];

  always_comb begin
    state_nxt = state_r;
    sec_nxt   = sec_r;
    step_nxt  = step_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_RUN;
          sec_nxt   = lr4_pkg::SEC_LOW1;
          step_nxt  = lr4_pkg::STEP_LOAD;
        end
      end
      ST_RUN: begin
        step_nxt = step_r + 3'd1;
        if (step_r == lr4_pkg::STEP_WB) begin
          sec_nxt = sec_r + 2'd1;
          if (sec_r == lr4_pkg::SEC_HIGH2) begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        if (push) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    if (push) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // command decode for the current step
  always_comb begin
    cmd         = '0;
    cmd.mul_sel = lr4_pkg::MS_A1_IC1;
    cmd.acc_op  = lr4_pkg::ACC_HOLD;
    cmd.take_in = in_valid && in_ready;
    cmd.push    = push;
    cmd.sec     = sec_r;
    if (state_r == ST_RUN) begin
      unique case (step_r)
        lr4_pkg::STEP_LOAD: cmd.load = 1'b1;
        lr4_pkg::STEP_M_A1: cmd.mul_sel = lr4_pkg::MS_A1_IC1;
        lr4_pkg::STEP_M_A2V: begin
          cmd.mul_sel = lr4_pkg::MS_A2_V3;
          cmd.acc_op  = lr4_pkg::ACC_LOAD;
        end
        lr4_pkg::STEP_M_A2I: begin
          cmd.mul_sel = lr4_pkg::MS_A2_IC1;
          cmd.acc_op  = lr4_pkg::ACC_ADD;
        end
        lr4_pkg::STEP_M_A3: begin
          cmd.mul_sel = lr4_pkg::MS_A3_V3;
          cmd.acc_op  = lr4_pkg::ACC_LOAD;
          cmd.v1_we   = 1'b1;
        end
        lr4_pkg::STEP_M_K: begin
          cmd.mul_sel = lr4_pkg::MS_K_V1;
          cmd.acc_op  = lr4_pkg::ACC_ADD;
        end
        lr4_pkg::STEP_V2: begin
          cmd.acc_op = is_high ? lr4_pkg::ACC_LOAD : lr4_pkg::ACC_HOLD;
          cmd.v2_we  = 1'b1;
        end
        lr4_pkg::STEP_WB: cmd.wb = 1'b1;
        default: cmd.load = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      sec_r       <= '0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sec_r       <= sec_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef SYNTHESIS
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=>
      (state_r == ST_RUN && sec_r == lr4_pkg::SEC_LOW1 && step_r == lr4_pkg::STEP_LOAD))
    else $error("item accepted but sequence did not start at the first section");

  a_last_wb: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN && sec_r == lr4_pkg::SEC_HIGH2 && step_r == lr4_pkg::STEP_WB) |=>
      (state_r == ST_DONE))
    else $error("last section finished without moving to result hand-off");

  a_result_once: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && !out_valid_r) |=> (out_valid_r && state_r == ST_IDLE))
    else $error("finished result not presented on a free output register");

  a_wb_after_v2: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wb |-> $past(cmd.v2_we))
    else $error("state write-back without v2 update in the previous cycle");
`endif

endmodule

FILE: hw/rtl/lr4_dp.sv
// datapath for the lr4 crossover: coefficient registers, integrator states,
// one shared multiplier with accumulator and the output register; depends on lr4_pkg
module lr4_dp (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     cfg_we,
  input  logic [lr4_pkg::CFG_IDX_W-1:0]            cfg_index,
  input  logic [lr4_pkg::COEF_W-1:0]               cfg_data,
  input  logic signed [lr4_pkg::SAMPLE_BITS-1:0]   in_sample_in,
  input  logic                                     in_block_end,
  input  lr4_pkg::dp_cmd_t                         cmd,
  output logic signed [lr4_pkg::SAMPLE_BITS-1:0]   out_low_band,
  output logic signed [lr4_pkg::SAMPLE_BITS-1:0]   out_high_band,
  output logic                                     out_block_end_out
);

  localparam int SB     = lr4_pkg::SAMPLE_BITS;
  localparam int CF     = lr4_pkg::COEF_FRAC_BITS;
  localparam int CW     = lr4_pkg::COEF_W;
  localparam int SW     = lr4_pkg::STATE_W;
  localparam int OW     = lr4_pkg::OPB_W;
  localparam int PW     = lr4_pkg::PROD_W;
  localparam int AW     = lr4_pkg::ACC_W;
  localparam int RW     = lr4_pkg::RND_W;
  localparam int WIDE_W = RW + 4;
  localparam int NS     = lr4_pkg::NUM_SEC;

  localparam logic signed [AW-1:0] RND_HALF =
    {{(AW - CF){1'b0}}, 1'b1, {(CF - 1){1'b0}}};

  function automatic logic signed [SW-1:0] sat_state(input logic signed [WIDE_W-1:0] x);
    logic [WIDE_W-SW:0] top;
    top = x[WIDE_W-1:SW-1];
    if (top == '0 || top == '1) begin
      return $signed(x[SW-1:0]);
    end else if (x[WIDE_W-1]) begin
      return $signed({1'b1, {(SW - 1){1'b0}}});
    end else begin
      return $signed({1'b0, {(SW - 1){1'b1}}});
    end
  endfunction

  function automatic logic signed [SB-1:0] sat_sample(input logic signed [SW-1:0] x);
    logic [SW-SB:0] top;
    top = x[SW-1:SB-1];
    if (top == '0 || top == '1) begin
      return $signed(x[SB-1:0]);
    end else if (x[SW-1]) begin
      return $signed({1'b1, {(SB - 1){1'b0}}});
    end else begin
      return $signed({1'b0, {(SB - 1){1'b1}}});
    end
  endfunction

  // coefficients kept already clamped to one
  logic [CW-1:0]          coef_a1_r, coef_a2_r, coef_a3_r;
  logic [CW-1:0]          cfg_clamped;

  logic signed [SW-1:0]   ic1_mem_r [NS];
  logic signed [SW-1:0]   ic2_mem_r [NS];

  logic signed [SB-1:0]   sample_r;
  logic                   bend_r;
  logic signed [SW-1:0]   x_r, ic1_r, ic2_r, v1_r, v2_r, lp_r, hp_r;
  logic signed [OW-1:0]   v3_r, v3_nxt;
  logic signed [PW-1:0]   prod_r, prod_nxt;
  logic signed [AW-1:0]   acc_r, acc_nxt, acc_rnd;
  logic signed [RW-1:0]   rnd;

  logic signed [SW-1:0]   in_sel;
  logic [CW-1:0]          opa;
  logic signed [OW-1:0]   opb;
  logic signed [CW:0]     opa_s;
  logic signed [SW-1:0]   v1_nxt, v2_nxt, hp_nxt, ic1_new, ic2_new;

  logic signed [SB-1:0]   low_r, high_r;
  logic                   bend_out_r;

  assign cfg_clamped = (cfg_data > lr4_pkg::COEF_ONE) ? lr4_pkg::COEF_ONE : cfg_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_a1_r <= lr4_pkg::COEF_A1_RESET;
      coef_a2_r <= lr4_pkg::COEF_A2_RESET;
      coef_a3_r <= lr4_pkg::COEF_A3_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lr4_pkg::CFG_A1: coef_a1_r <= cfg_clamped;
        lr4_pkg::CFG_A2: coef_a2_r <= cfg_clamped;
        lr4_pkg::CFG_A3: coef_a3_r <= cfg_clamped;
        default: coef_a1_r <= coef_a1_r;
      endcase
    end
  end

  // section input: first sections take the sample, second ones the first's output
  always_comb begin
    case (cmd.sec) inside
      lr4_pkg::SEC_LOW1, lr4_pkg::SEC_HIGH1: in_sel = SW'(sample_r);
      lr4_pkg::SEC_LOW2: in_sel = lp_r;
      default:           in_sel = hp_r;
    endcase
  end

  assign v3_nxt = OW'(in_sel) - OW'(ic2_mem_r[cmd.sec]);

  always_comb begin
    case (cmd.mul_sel)
      lr4_pkg::MS_A1_IC1: begin
        opa = coef_a1_r;
        opb = OW'(ic1_r);
      end
      lr4_pkg::MS_A2_V3: begin
        opa = coef_a2_r;
        opb = v3_r;
      end
      lr4_pkg::MS_A2_IC1: begin
        opa = coef_a2_r;
        opb = OW'(ic1_r);
      end
      lr4_pkg::MS_A3_V3: begin
        opa = coef_a3_r;
        opb = v3_r;
      end
      lr4_pkg::MS_K_V1: begin
        opa = lr4_pkg::K_SQRT2;
        opb = OW'(v1_r);
      end
      default: begin
        opa = '0;
        opb = '0;
      end
    endcase
  end

  assign opa_s    = $signed({1'b0, opa});
  assign prod_nxt = opa_s * opb;

  always_comb begin
    case (cmd.acc_op)
      lr4_pkg::ACC_LOAD: acc_nxt = AW'(prod_r);
      lr4_pkg::ACC_ADD:  acc_nxt = acc_r + AW'(prod_r);
      default:           acc_nxt = acc_r;
    endcase
  end

  // round half up to the sample lsb
  assign acc_rnd = acc_r + RND_HALF;
  assign rnd     = $signed(acc_rnd[AW-1:CF]);

  assign v1_nxt  = sat_state(WIDE_W'(rnd));
  assign v2_nxt  = sat_state(WIDE_W'(ic2_r) + WIDE_W'(rnd));
  assign hp_nxt  = sat_state(WIDE_W'(x_r) - WIDE_W'(rnd) - WIDE_W'(v2_r));
  assign ic1_new = sat_state((WIDE_W'(v1_r) <<< 1) - WIDE_W'(ic1_r));
  assign ic2_new = sat_state((WIDE_W'(v2_r) <<< 1) - WIDE_W'(ic2_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NS; i++) begin
        ic1_mem_r[i] <= '0;
        ic2_mem_r[i] <= '0;
      end
    end else if (cmd.wb) begin
      ic1_mem_r[cmd.sec] <= ic1_new;
      ic2_mem_r[cmd.sec] <= ic2_new;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_in) begin
      sample_r <= in_sample_in;
      bend_r   <= in_block_end;
    end
    if (cmd.load) begin
      x_r   <= in_sel;
      ic1_r <= ic1_mem_r[cmd.sec];
      ic2_r <= ic2_mem_r[cmd.sec];
      v3_r  <= v3_nxt;
    end
    prod_r <= prod_nxt;
    acc_r  <= acc_nxt;
    if (cmd.v1_we) begin
      v1_r <= v1_nxt;
    end
    if (cmd.v2_we) begin
      v2_r <= v2_nxt;
    end
    if (cmd.wb) begin
      if (cmd.sec[0]) begin
        hp_r <= hp_nxt;
      end else begin
        lp_r <= v2_r;
      end
    end
    if (cmd.push) begin
      low_r      <= sat_sample(lp_r);
      high_r     <= sat_sample(hp_r);
      bend_out_r <= bend_r;
    end
  end

  assign out_low_band      = low_r;
  assign out_high_band     = high_r;
  assign out_block_end_out = bend_out_r;

endmodule
